>>> hw/rtl/urb_pkg.sv
package urb_pkg;

	localparam int RX_DEPTH_DEF = 64;
	localparam int TX_DEPTH_DEF = 64;

	// request codes
	localparam logic [1:0] REQ_POLL = 2'd0;
	localparam logic [1:0] REQ_PUT  = 2'd1;
	localparam logic [1:0] REQ_GET  = 2'd2;
	localparam logic [1:0] REQ_HEX  = 2'd3;

	localparam logic [7:0] ASCII_DIGIT_BASE = 8'h30;
	localparam logic [7:0] ASCII_ALPHA_BASE = 8'h37;
	localparam logic [7:0] NIBBLE_MASK      = 8'h0f;

	typedef struct packed {
		logic [1:0] req_type;
		logic       overrun_flag;
		logic       framing_flag;
		logic       rx_ready;
		logic [7:0] rx_byte;
		logic       tx_empty;
		logic [7:0] put_byte;
	} urb_req_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       restart_receiver;
		logic       get_valid;
		logic [7:0] get_byte;
		logic       rx_available;
		logic       tx_busy;
		logic [7:0] errors_seen;
	} urb_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic finish;
	} urb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} urb_sts_t;

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		logic [7:0] v;
		v = {4'd0, n} & NIBBLE_MASK;
		if (v <= 8'd9) begin
			return v + ASCII_DIGIT_BASE;
		end
		return v + ASCII_ALPHA_BASE;
	endfunction

endpackage

>>> hw/rtl/urb_ifs.sv
interface urb_req_if
	import urb_pkg::*;
();
	logic     valid;
	logic     ready;
	urb_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface urb_rsp_if
	import urb_pkg::*;
();
	logic     valid;
	logic     ready;
	urb_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/urb_ctrl.sv
module urb_ctrl
	import urb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  urb_sts_t sts,
	output urb_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	assign req_ready  = (state_q == ST_IDLE) && sts.out_free;
	assign cmd.accept = req_valid && req_ready;
	assign cmd.finish = (state_q == ST_EXEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/urb_datapath.sv
module urb_datapath
	import urb_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  urb_cmd_t cmd,
	output urb_sts_t sts,
	input  urb_req_t req_data,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output urb_rsp_t rsp_data
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_mem [TX_DEPTH];

	logic [RX_AW-1:0] rx_wr_q, rx_rd_q;
	logic [TX_AW-1:0] tx_wr_q, tx_rd_q;
	logic [7:0]       tally_q;
	logic             busy_q;
	logic             quiet_q;

	logic [7:0] rx_rdata_q, tx_rdata_q;
	logic       send_q, restart_q, hit_q, hex_q;
	logic [3:0] hex_lo_q;

	logic       rsp_valid_q;
	urb_rsp_t   rsp_q;

	logic       is_poll, is_put, is_get, is_hex;
	logic       rx_push, send, get_hit, err_any, hex2;
	logic [1:0] err_inc;
	logic       tx_we;
	logic [7:0] tx_wdata;

	assign is_poll = cmd.accept && (req_data.req_type == REQ_POLL);
	assign is_put  = cmd.accept && (req_data.req_type == REQ_PUT);
	assign is_get  = cmd.accept && (req_data.req_type == REQ_GET);
	assign is_hex  = cmd.accept && (req_data.req_type == REQ_HEX);

	// framing error drops the byte, overrun alone does not
	assign rx_push = is_poll && !req_data.framing_flag && req_data.rx_ready;
	assign send    = is_poll && req_data.tx_empty && (tx_wr_q != tx_rd_q) && !quiet_q;
	assign get_hit = is_get && (rx_wr_q != rx_rd_q);
	assign err_inc = {1'b0, req_data.overrun_flag} + {1'b0, req_data.framing_flag};
	assign err_any = req_data.overrun_flag || req_data.framing_flag;
	assign hex2    = cmd.finish && hex_q;

	// tx ring write port: put, high hex digit at accept, low digit in the execute state that follows
	always_comb begin
		tx_we    = is_put || is_hex || hex2;
		tx_wdata = req_data.put_byte;
		if (is_hex) begin
			tx_wdata = nibble_char(req_data.put_byte[7:4]);
		end else if (hex2) begin
			tx_wdata = nibble_char(hex_lo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (rx_push) begin
			rx_mem[rx_wr_q] <= req_data.rx_byte;
		end
		if (get_hit) begin
			rx_rdata_q <= rx_mem[rx_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wr_q] <= tx_wdata;
		end
		if (send) begin
			tx_rdata_q <= tx_mem[tx_rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr_q   <= '0;
			rx_rd_q   <= '0;
			tx_wr_q   <= '0;
			tx_rd_q   <= '0;
			tally_q   <= '0;
			busy_q    <= 1'b0;
			quiet_q   <= 1'b0;
			send_q    <= 1'b0;
			restart_q <= 1'b0;
			hit_q     <= 1'b0;
			hex_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				quiet_q <= cfg_wdata;
			end
			if (rx_push) begin
				rx_wr_q <= (rx_wr_q == RX_LAST) ? '0 : rx_wr_q + 1'b1;
			end
			if (get_hit) begin
				rx_rd_q <= (rx_rd_q == RX_LAST) ? '0 : rx_rd_q + 1'b1;
			end
			if (tx_we) begin
				tx_wr_q <= (tx_wr_q == TX_LAST) ? '0 : tx_wr_q + 1'b1;
			end
			if (send) begin
				tx_rd_q <= (tx_rd_q == TX_LAST) ? '0 : tx_rd_q + 1'b1;
			end
			if (is_poll) begin
				tally_q <= tally_q + {6'd0, err_inc};
				if (req_data.tx_empty) begin
					busy_q <= send;
				end
			end
			if (cmd.accept) begin
				send_q    <= send;
				restart_q <= is_poll && err_any;
				hit_q     <= get_hit;
				hex_q     <= is_hex;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hex_lo_q <= req_data.put_byte[3:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.tx_valid         <= send_q;
			rsp_q.tx_byte          <= send_q ? tx_rdata_q : 8'd0;
			rsp_q.restart_receiver <= restart_q;
			rsp_q.get_valid        <= hit_q;
			rsp_q.get_byte         <= hit_q ? rx_rdata_q : 8'd0;
			rsp_q.rx_available     <= (rx_wr_q != rx_rd_q);
			rsp_q.tx_busy          <= busy_q;
			rsp_q.errors_seen      <= tally_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;
	assign sts.out_free = !rsp_valid_q || rsp_ready;

endmodule

>>> hw/rtl/uart_ring_buffer_controller.sv
// Result: a taken request beat moves the sequencer to its execute state, and the result
//   beat is registered at the end of the execute state.
// Requests: one at a time; no request is taken during the execute state. The accept
//   cycle issues ring memory reads and writes, the execute state takes the registered
//   read data (and writes the low digit of a hex put). A waiting result holds off new
//   requests; the next request is taken in the same cycle as the waiting result beat.
// Reset (arst_n, async, active low): ring pointers, error count, busy flag and
//   quiet mode clear; ring contents are not cleared and need no clearing pass.
module uart_ring_buffer_controller
	import urb_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	urb_req_if.sink   req,
	urb_rsp_if.source rsp
);

	urb_cmd_t cmd;
	urb_sts_t sts;

	// Sequencer: idle until a request beat is taken, then an execute state, then back to idle.
	urb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Rings, pointers, error count, busy flag, quiet mode and result register.
	// Overflow wraps the write pointer and silently loses the ring contents.
	urb_datapath #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule

>>> hw/rtl/urb_checker.sv
module urb_checker
	import urb_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input urb_rsp_t rsp_data
);

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result beat dropped or changed while stalled");

	// one request at a time: no back-to-back accepts
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during execute cycle");

	// data bytes are zero unless flagged
	a_zero_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.tx_valid || rsp_data.tx_byte == 8'd0)
			&& (rsp_data.get_valid || rsp_data.get_byte == 8'd0))
		else $error("unflagged byte not zero");

	// a get result never carries poll side effects
	a_get_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.get_valid |-> !rsp_data.tx_valid && !rsp_data.restart_receiver)
		else $error("get and poll results mixed");

endmodule

bind uart_ring_buffer_controller urb_checker u_urb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
